// File: rtl/rau_pkg.sv
package rau_pkg;

  localparam int VW = 32;
  localparam int PW = 2 * VW + 1;
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_EQ  = 3'd4, OP_LT  = 3'd5, OP_GT  = 3'd6, OP_RED = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_DIV0 = 2'd2, ST_OVF = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [VW-1:0] num_a;
    logic signed [VW-1:0] den_a;
    logic signed [VW-1:0] num_b;
    logic signed [VW-1:0] den_b;
  } req_t;

  typedef struct packed {
    logic signed [VW-1:0] res_num;
    logic [VW-2:0]        res_den;
    logic                 cmp_true;
    logic [1:0]           status;
  } rsp_t;

  // Datapath commands from the controller.
  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_MUL1, C_MUL2, C_FORM, C_GSTART, C_DSTEP, C_GSWAP,
    C_QNUM, C_QDEN, C_FIN
  } cmd_t;

  typedef struct packed {
    logic early;     // error or compare already decided at load
    logic div_last;  // divider on its final step
    logic rem_zero;  // gcd loop divisor is zero
  } dp_stat_t;

endpackage

// File: rtl/rau_ctrl.sv
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_go,
  input  logic     out_take,
  input  dp_stat_t st,
  output cmd_t     cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GCHK, S_GDIV, S_QN_S, S_QN, S_QD_S,
    S_QD, S_FIN, S_OUT
  } state_t;

  state_t state;

  // Command decode from state.
  always_comb begin
    cmd = C_NONE;
    unique case (state)
      S_IDLE: cmd = in_go ? C_LOAD : C_NONE;
      S_MUL1: cmd = C_MUL1;
      S_MUL2: cmd = C_MUL2;
      S_FORM: cmd = C_FORM;
      S_GCHK: cmd = st.rem_zero ? C_NONE : C_GSTART;
      S_GDIV: cmd = st.div_last ? C_GSWAP : C_DSTEP;
      S_QN_S: cmd = C_QNUM;
      S_QN:   cmd = C_DSTEP;
      S_QD_S: cmd = C_QDEN;
      S_QD:   cmd = C_DSTEP;
      S_FIN:  cmd = C_FIN;
      S_OUT:  cmd = C_NONE;
      default: cmd = C_NONE;
    endcase
  end

  assign busy = (state != S_IDLE) && (state != S_OUT);
  assign done = (state == S_OUT);

  // Sequencer: multiply, gcd loop, two exact divisions, finish.
  // Errors and compares leave after the products, which the compare needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_go) state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= st.early ? S_OUT : S_FORM;
        S_FORM: state <= S_GCHK;
        S_GCHK: state <= st.rem_zero ? S_QN_S : S_GDIV;
        S_GDIV: if (st.div_last) state <= S_GCHK;
        S_QN_S: state <= S_QN;
        S_QN:   if (st.div_last) state <= S_QD_S;
        S_QD_S: state <= S_QD;
        S_QD:   if (st.div_last) state <= S_FIN;
        S_FIN:  state <= S_OUT;
        S_OUT:  if (out_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rau_dp.sv
module rau_dp import rau_pkg::*; (
  input  logic     clk,
  input  cmd_t     cmd,
  input  req_t     req,
  output dp_stat_t st,
  output rsp_t     rsp
);

  logic [2:0]      op;
  logic [VW-1:0]   na, da, nb, db;
  logic            an, bn, rn;
  logic [2*VW-1:0] p1, p2, p3;
  logic [PW-1:0]   num, den, ga, gb;
  logic [PW-1:0]   dn, dd, rem;
  logic [CW-1:0]   cnt;
  logic            early;
  rsp_t            res;

  logic [VW-1:0] mna, mda, mnb, mdb;
  logic          sna, sda, snb, sdb;
  logic [PW:0]   trial;
  logic [PW-1:0] rsh;
  logic          cz1, cz2;
  logic [2*VW:0] sa, sb;
  logic [VW-1:0] maxpos;
  logic          isc, cres;
  status_t       ld_status;
  logic          ld_cmp;

  function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : v;
  endfunction

  assign sna = req.num_a[VW-1];
  assign sda = req.den_a[VW-1];
  assign snb = req.num_b[VW-1];
  assign sdb = req.den_b[VW-1];
  assign mna = mag(req.num_a);
  assign mda = mag(req.den_a);
  assign mnb = mag(req.num_b);
  assign mdb = mag(req.den_b);

  // Status of an incoming word, decided before any arithmetic.
  assign ld_cmp = (req.req_type == OP_EQ) || (req.req_type == OP_LT) ||
                  (req.req_type == OP_GT);
  always_comb begin
    priority if (mda == '0 || (req.req_type != OP_RED && mdb == '0))
      ld_status = ST_ZDEN;
    else if (req.req_type == OP_DIV && mnb == '0)
      ld_status = ST_DIV0;
    else
      ld_status = ST_OK;
  end

  // One restoring division step.
  assign rsh   = {rem[PW-2:0], dn[PW-1]};
  assign trial = {1'b0, rsh} - {1'b0, dd};

  assign maxpos = {1'b0, {(VW-1){1'b1}}};
  assign isc    = (op == OP_EQ) || (op == OP_LT) || (op == OP_GT);

  // Signed compare of an*p1 against bn*p2.
  assign cz1 = (p1 == '0);
  assign cz2 = (p2 == '0);
  always_comb begin
    logic xn, yn;
    xn = an && !cz1;
    yn = bn && !cz2;
    if (op == OP_EQ)      cres = (xn == yn) && (p1 == p2);
    else if (op == OP_LT) cres = (xn != yn) ? xn : (xn ? (p1 > p2) : (p1 < p2));
    else                  cres = (xn != yn) ? yn : (xn ? (p1 < p2) : (p1 > p2));
  end

  assign sa = {1'b0, p1};
  assign sb = {1'b0, p2};

  assign st.early    = early;
  assign st.div_last = (cnt == CW'(PW - 1));
  assign st.rem_zero = (gb == '0);
  assign rsp = res;

  always_ff @(posedge clk) begin
    unique case (cmd)
      C_LOAD: begin
        op <= req.req_type;
        na <= mna; da <= mda; nb <= mnb; db <= mdb;
        an <= sna ^ sda;
        bn <= (snb ^ sdb) ^ (req.req_type == OP_SUB);
        early <= (ld_status != ST_OK) || ld_cmp;
        res <= '{res_num: '0, res_den: (VW-1)'(1), cmp_true: 1'b0,
                 status: ld_status};
      end
      C_MUL1: begin
        // Cross products (compare/add/sub) or direct products.
        unique case (op)
          OP_MUL: begin p1 <= na * nb; p2 <= '0; end
          OP_DIV: begin p1 <= na * db; p2 <= '0; end
          OP_RED: begin p1 <= {{VW{1'b0}}, na}; p2 <= '0; end
          default: begin p1 <= na * db; p2 <= nb * da; end
        endcase
      end
      C_MUL2: begin
        unique case (op)
          OP_DIV: p3 <= da * nb;
          OP_RED: p3 <= {{VW{1'b0}}, da};
          default: p3 <= da * db;
        endcase
        if (isc && res.status == ST_OK) res.cmp_true <= cres;
      end
      C_FORM: begin
        den <= {1'b0, p3};
        if (op == OP_ADD || op == OP_SUB) begin
          if (an == bn) begin num <= sa + sb; rn <= an; end
          else if (p1 >= p2) begin num <= sa - sb; rn <= an; end
          else begin num <= sb - sa; rn <= bn; end
        end else begin
          num <= {1'b0, p1};
          rn  <= (op == OP_RED) ? an : (an ^ bn);
        end
        ga <= {1'b0, p3};
        gb <= (op == OP_ADD || op == OP_SUB) ? ((an == bn) ? sa + sb :
              (p1 >= p2) ? sa - sb : sb - sa) : {1'b0, p1};
      end
      C_GSTART: begin
        dn <= ga; dd <= gb; rem <= '0; cnt <= '0;
      end
      C_DSTEP, C_GSWAP: begin
        dn  <= {dn[PW-2:0], ~trial[PW]};
        rem <= trial[PW] ? rsh : trial[PW-1:0];
        cnt <= cnt + CW'(1);
        if (cmd == C_GSWAP) begin
          ga <= gb;
          gb <= trial[PW] ? rsh : trial[PW-1:0];
        end
      end
      C_QNUM: begin
        dn <= num; dd <= ga; rem <= '0; cnt <= '0;
      end
      C_QDEN: begin
        num <= dn;
        dn <= den; dd <= ga; rem <= '0; cnt <= '0;
      end
      C_FIN: begin
        // dn holds reduced den, num holds reduced num.
        if (dn > PW'(maxpos) ||
            num > (((num != '0) && rn) ? PW'(maxpos) + PW'(1) : PW'(maxpos))) begin
          res.status <= ST_OVF;
        end else begin
          res.res_num <= rn ? VW'(-num[VW-1:0]) : num[VW-1:0];
          res.res_den <= dn[VW-2:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit.
// Input channel: in_valid / in_stall with word in_data (opcode and two
// fractions). Output channel: out_valid / out_stall with word out_data
// (reduced fraction, compare flag, status). A word is accepted at a clock
// edge where valid is high and stall is low.
// One word is processed at a time; in_stall is high while busy and while
// a result is held. Errors and compares raise out_valid straight after
// the multiply states S_MUL1 and S_MUL2. In arithmetic, every
// division is a 65-step restoring divider, one bit per cycle, run once per
// Euclid step and then twice for the exact quotients.
// The result waits in an output register until out_stall is low; the
// next input word is taken in the cycle after that.
// Reset (rst, synchronous) returns the sequencer to idle and drops
// out_valid; no clearing pass is needed.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  cmd_t     cmd;
  dp_stat_t st;
  logic     busy, done, go;

  assign go        = in_valid && !in_stall;
  assign in_stall  = busy || done;
  assign out_valid = done;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(go), .out_take(!out_stall), .st(st),
    .cmd(cmd), .busy(busy), .done(done)
  );

  rau_dp u_dp (
    .clk(clk), .cmd(cmd), .req(in_data), .st(st), .rsp(out_data)
  );

  // Never accept input while a result is held.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input accepted with result pending");

  // Errors force the neutral fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.res_num == '0)
    else $error("error result carries nonzero numerator");

  // A held result stays while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rau_pkg::*;

  localparam int LIMIT = 30000000;
  localparam logic [127:0] MAXPOS = 128'h7fff_ffff;

  // Tracks expected result words and compares them with what comes out.
  class rational_scoreboard;
    rsp_t expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Magnitude of a two's complement operand.
    function logic [127:0] mag(logic [31:0] v);
      logic [31:0] u;
      u = v;
      if (v[31]) u = -v;
      return {96'b0, u};
    endfunction

    // Exact rational result of one request word.
    function rsp_t compute_result(req_t r);
      logic [127:0] na, da, nb, db, x, y, num, den, a, b, t;
      logic an, bn, ys, rn, xn, yn;
      int c;
      rsp_t o;
      o = '0;
      o.res_den = 31'(1);
      o.status = ST_OK;
      if (r.den_a == 0 || (r.req_type != OP_RED && r.den_b == 0)) begin
        o.status = ST_ZDEN;
        return o;
      end
      if (r.req_type == OP_DIV && r.num_b == 0) begin
        o.status = ST_DIV0;
        return o;
      end
      na = mag(r.num_a);
      da = mag(r.den_a);
      nb = mag(r.num_b);
      db = mag(r.den_b);
      an = r.num_a[31] ^ r.den_a[31];
      bn = r.num_b[31] ^ r.den_b[31];
      x = na * db;
      y = nb * da;
      rn = 1'b0;
      // Compares work on cross products; zero carries no sign.
      if (r.req_type inside {OP_EQ, OP_LT, OP_GT}) begin
        xn = an && (x != 0);
        yn = bn && (y != 0);
        if (xn != yn) c = xn ? -1 : 1;
        else c = (x == y) ? 0 : ((x < y) ? -1 : 1);
        if (xn && xn == yn) c = -c;
        case (r.req_type)
          OP_EQ: o.cmp_true = (c == 0);
          OP_LT: o.cmp_true = (c < 0);
          default: o.cmp_true = (c > 0);
        endcase
        return o;
      end
      case (r.req_type)
        OP_ADD, OP_SUB: begin
          ys = (r.req_type == OP_SUB) ? !bn : bn;
          if (an == ys) begin
            num = x + y;
            rn = an;
          end else if (x >= y) begin
            num = x - y;
            rn = an;
          end else begin
            num = y - x;
            rn = ys;
          end
          den = da * db;
        end
        OP_MUL: begin
          num = na * nb;
          den = da * db;
          rn = an ^ bn;
        end
        OP_DIV: begin
          num = na * db;
          den = da * nb;
          rn = an ^ bn;
        end
        default: begin
          num = na;
          den = da;
          rn = an;
        end
      endcase
      // Euclid, then divide both parts by the gcd.
      a = num;
      b = den;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      num = num / a;
      den = den / a;
      if (num == 0) rn = 1'b0;
      if (den > MAXPOS || num > (rn ? MAXPOS + 1 : MAXPOS)) begin
        o.status = ST_OVF;
        return o;
      end
      o.res_num = rn ? -num[31:0] : num[31:0];
      o.res_den = den[30:0];
      return o;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(compute_result(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.res_num !== e.res_num) begin
        $error("res_num: expected %0d, got %0d", e.res_num, got.res_num);
        errors++;
      end
      if (got.res_den !== e.res_den) begin
        $error("res_den: expected %0d, got %0d", e.res_den, got.res_den);
        errors++;
      end
      if (got.cmp_true !== e.cmp_true) begin
        $error("cmp_true: expected %0d, got %0d", e.cmp_true, got.cmp_true);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  rational_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_off;
  logic start_hold;
  int unsigned cycle_count;

  rational_arithmetic_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: check each accepted word, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    hold_off = 1'b0;
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (4000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Present one word and wait until it is taken.
  task automatic send_word(req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  // Sender gaps after a word, decided cycle by cycle.
  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 50) return 32'($signed($urandom_range(2000)) - 1000);
    if (k < 60) return 32'($urandom_range(65535));
    if (k < 80) return $urandom;
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      default: return 32'h8000_0001;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.req_type = op_t'($urandom_range(7));
    r.num_a = rand_value();
    r.den_a = rand_value();
    r.num_b = rand_value();
    r.den_b = rand_value();
    return r;
  endfunction

  function automatic req_t mk(op_t op, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic [31:0] d);
    req_t r;
    r.req_type = op;
    r.num_a = a;
    r.den_a = b;
    r.num_b = c;
    r.den_b = d;
    return r;
  endfunction

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      send_word(rand_req());
      sender_gap();
    end
  endtask

  initial begin
    req_t dir_q[$];
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    start_hold = 1'b0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words: every opcode, range extremes and error cases.
    dir_q.push_back(mk(OP_ADD, 1, 2, 1, 3));
    dir_q.push_back(mk(OP_SUB, 1, 2, 1, 2));
    dir_q.push_back(mk(OP_MUL, -3, 4, 8, -9));
    dir_q.push_back(mk(OP_DIV, 3, 4, -6, 8));
    dir_q.push_back(mk(OP_EQ, 1, 2, -2, -4));
    dir_q.push_back(mk(OP_LT, -1, 2, 1, 3));
    dir_q.push_back(mk(OP_GT, 5, -7, 2, 3));
    dir_q.push_back(mk(OP_RED, 12, -18, 0, 0));
    dir_q.push_back(mk(OP_ADD, 1, 0, 1, 2));
    dir_q.push_back(mk(OP_LT, 1, 2, 1, 0));
    dir_q.push_back(mk(OP_RED, 1, 0, 5, 7));
    dir_q.push_back(mk(OP_DIV, 1, 2, 0, 5));
    dir_q.push_back(mk(OP_MUL, 32'h7fff_ffff, 1, 2, 1));
    dir_q.push_back(mk(OP_RED, 32'h8000_0000, 1, 0, 1));
    dir_q.push_back(mk(OP_RED, 32'h8000_0000, 32'hffff_ffff, 0, 1));
    dir_q.push_back(mk(OP_RED, 1, 32'h8000_0000, 0, 1));
    dir_q.push_back(mk(OP_RED, 2, 32'h8000_0000, 0, 1));
    dir_q.push_back(mk(OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000,
                       32'h7fff_ffff));
    dir_q.push_back(mk(OP_MUL, 0, 5, 32'h8000_0000, 3));
    dir_q.push_back(mk(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0001));
    dir_q.push_back(mk(OP_EQ, 32'h8000_0000, 32'h8000_0000, 1, 1));
    dir_q.push_back(mk(OP_GT, 0, -5, 0, 7));
    dir_q.push_back(mk(OP_DIV, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1));
    foreach (dir_q[i]) send_word(dir_q[i]);

    // Random words under the different idling patterns.
    random_phase(200, 0, 0);
    random_phase(200, 88, 0);
    random_phase(200, 0, 88);
    random_phase(200, 18, 18);

    // Receiver holds off while the sender keeps offering words.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    start_hold = 1'b1;
    random_phase(30, 0, 0);

    // Sender pauses until every result is back.
    drain();
    random_phase(200, 0, 0);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit.sv
tb/sv/tb_top.sv
